### sv/dfrb_pkg.sv
// Shared types and constants for the dim factor ramp brightness block.
`default_nettype none

package dfrb_pkg;

    // Factor format: Q1.FRAC_BITS, ONE_Q means 1.0
    localparam int FRAC_BITS = 15;
    localparam int FW        = FRAC_BITS + 1;
    localparam int TIME_W    = 32;
    localparam int FADE_W    = 10;
    localparam int BRT_W     = 8;
    localparam int TGT_W     = 16;

    localparam int SPAN_W = FW + 1;
    localparam int PROD_W = SPAN_W + FADE_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [FW-1:0] ONE_Q  = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] HALF_Q = FW'(1) << (FRAC_BITS - 1);
    // ceil(0.999 * ONE)
    localparam logic [FW-1:0] PASS_Q =
        FW'((999 * (longint'(1) << FRAC_BITS) + 999) / 1000);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMP_BRIGHTNESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MS         = 2'd2;

    localparam logic [BRT_W-1:0]  BRT_RESET  = 8'd255;
    localparam logic [FADE_W-1:0] FADE_RESET = 10'd80;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [TGT_W-1:0]  target_factor;
        logic              home_mode;
    } in_item_t;

    typedef struct packed {
        logic [BRT_W-1:0] brightness;
        logic [TGT_W-1:0] factor_now;
    } out_item_t;

endpackage

`default_nettype wire

### sv/dim_factor_ramp_brightness_core.sv
// Top level: retriggerable linear dim factor ramp and brightness scaling.
//
// Each input item is one frame tick. An item whose time stamp lies inside a running
// ramp passes from the accepting edge through a set-up state (span times elapsed),
// a serial restoring divider by fade_ms (one quotient bit per cycle), a state to
// add the step, one to scale the brightness and one to present the result.
// Items that need no interpolation skip the divider and the add step. in_stall
// stays high from acceptance until the result has been taken. cfg_ready is always
// high; registers are to be written only while the block is idle.
`default_nettype none

module dim_factor_ramp_brightness_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire dfrb_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output dfrb_pkg::out_item_t                out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dfrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);

    localparam int FW     = dfrb_pkg::FW;
    localparam int TIME_W = dfrb_pkg::TIME_W;
    localparam int FADE_W = dfrb_pkg::FADE_W;
    localparam int BRT_W  = dfrb_pkg::BRT_W;
    localparam int SPAN_W = dfrb_pkg::SPAN_W;
    localparam int PROD_W = dfrb_pkg::PROD_W;
    localparam int CNT_W  = dfrb_pkg::CNT_W;
    localparam int SCL_W  = BRT_W + FW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [BRT_W-1:0]  home_reg;
    logic [BRT_W-1:0]  lamp_reg;
    logic [FADE_W-1:0] fade_reg;

    // ramp state
    logic [FW-1:0]     from_reg;
    logic [FW-1:0]     to_reg;
    logic [TIME_W-1:0] start_reg;
    logic              running_reg;

    // per-item working registers
    logic [TIME_W-1:0] now_reg;
    logic [FW-1:0]     tgt_reg;
    logic [BRT_W-1:0]  raw_reg;
    logic [FW-1:0]     factor_reg;
    logic [FW-1:0]     base_reg;
    logic              neg_reg;
    logic              upd_from_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [FADE_W:0]   rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    dfrb_pkg::out_item_t out_reg;

    // combinational terms
    logic [FW-1:0]       tgt_sat;
    logic [TIME_W-1:0]   elapsed;
    logic                in_ramp;
    logic                retrig;
    logic signed [SPAN_W-1:0] span;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]   prod_mag;
    logic [FADE_W:0]     rem_shift;
    logic                rem_ge;
    logic [PROD_W-1:0]   step;
    logic [PROD_W-1:0]   lerp_sum;
    logic [SCL_W-1:0]    scaled;
    logic [SCL_W-dfrb_pkg::FRAC_BITS-1:0] scaled_hi;
    logic [BRT_W-1:0]    bright;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        tgt_sat = (in_data.target_factor > dfrb_pkg::TGT_W'(dfrb_pkg::ONE_Q))
                  ? dfrb_pkg::ONE_Q : in_data.target_factor[FW-1:0];
        elapsed = now_reg - start_reg;
        in_ramp = running_reg && (elapsed < {{(TIME_W-FADE_W){1'b0}}, fade_reg});
        retrig  = (tgt_reg != to_reg);

        // elapsed < fade_ms whenever this product is used, so its low bits suffice
        span     = $signed({1'b0, to_reg}) - $signed({1'b0, from_reg});
        prod     = span * $signed({1'b0, elapsed[FADE_W-1:0]});
        prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

        rem_shift = {rem_reg[FADE_W-1:0], dvd_reg[PROD_W-1]};
        rem_ge    = (rem_shift >= {1'b0, fade_reg});

        // truncation toward zero: divide magnitude, then restore the sign
        step     = neg_reg ? (~dvd_reg + PROD_W'(1)) : dvd_reg;
        lerp_sum = {{(PROD_W-FW){1'b0}}, base_reg} + step;

        scaled    = SCL_W'(raw_reg) * SCL_W'(factor_reg) + SCL_W'(dfrb_pkg::HALF_Q);
        scaled_hi = scaled[SCL_W-1:dfrb_pkg::FRAC_BITS];
        if (factor_reg >= dfrb_pkg::PASS_Q)
        begin
            bright = raw_reg;
        end
        else if (scaled_hi > (SCL_W-dfrb_pkg::FRAC_BITS)'(255))
        begin
            bright = BRT_W'(255);
        end
        else if (scaled_hi == '0)
        begin
            bright = BRT_W'(1);
        end
        else
        begin
            bright = scaled_hi[BRT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            home_reg      <= dfrb_pkg::BRT_RESET;
            lamp_reg      <= dfrb_pkg::BRT_RESET;
            fade_reg      <= dfrb_pkg::FADE_RESET;
            from_reg      <= dfrb_pkg::ONE_Q;
            to_reg        <= dfrb_pkg::ONE_Q;
            start_reg     <= '0;
            running_reg   <= 1'b0;
            upd_from_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dfrb_pkg::CFG_HOME_BRIGHTNESS: home_reg <= cfg_data[BRT_W-1:0];
                    dfrb_pkg::CFG_LAMP_BRIGHTNESS: lamp_reg <= cfg_data[BRT_W-1:0];
                    dfrb_pkg::CFG_FADE_MS:         fade_reg <= cfg_data[FADE_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        now_reg   <= in_data.now_ms;
                        tgt_reg   <= tgt_sat;
                        raw_reg   <= in_data.home_mode ? home_reg : lamp_reg;
                        state_reg <= ST_PREP;
                    end
                end

                ST_PREP:
                begin
                    // operands for a possible lerp of the ramp as it stands
                    base_reg     <= from_reg;
                    neg_reg      <= prod[PROD_W-1];
                    dvd_reg      <= prod_mag;
                    rem_reg      <= '0;
                    cnt_reg      <= CNT_W'(PROD_W - 1);
                    upd_from_reg <= 1'b0;
                    if (retrig)
                    begin
                        to_reg      <= tgt_reg;
                        start_reg   <= now_reg;
                        running_reg <= 1'b1;
                        if (in_ramp)
                        begin
                            // retrigger mid-fade: new ramp starts at the lerp point
                            upd_from_reg <= 1'b1;
                            state_reg    <= ST_DIV;
                        end
                        else if (fade_reg == '0)
                        begin
                            from_reg    <= tgt_reg;
                            running_reg <= 1'b0;
                            factor_reg  <= tgt_reg;
                            state_reg   <= ST_SCALE;
                        end
                        else
                        begin
                            from_reg   <= running_reg ? to_reg : from_reg;
                            factor_reg <= running_reg ? to_reg : from_reg;
                            state_reg  <= ST_SCALE;
                        end
                    end
                    else if (!running_reg)
                    begin
                        factor_reg <= to_reg;
                        state_reg  <= ST_SCALE;
                    end
                    else if (!in_ramp)
                    begin
                        from_reg    <= to_reg;
                        running_reg <= 1'b0;
                        factor_reg  <= to_reg;
                        state_reg   <= ST_SCALE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    rem_reg <= rem_ge ? (rem_shift - {1'b0, fade_reg}) : rem_shift;
                    dvd_reg <= {dvd_reg[PROD_W-2:0], rem_ge};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end

                ST_FIN:
                begin
                    factor_reg <= lerp_sum[FW-1:0];
                    if (upd_from_reg)
                    begin
                        from_reg <= lerp_sum[FW-1:0];
                    end
                    state_reg <= ST_SCALE;
                end

                ST_SCALE:
                begin
                    out_reg.brightness <= bright;
                    out_reg.factor_now <= dfrb_pkg::TGT_W'(factor_reg);
                    out_valid_reg      <= 1'b1;
                    state_reg          <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
